@@ hdl/fcdf_pkg.sv @@
package fcdf_pkg;

  localparam int DEFAULT_MAX_WIDTH = 256;
  localparam int HEAT_W            = 8;
  localparam int POS_W             = 8;
  localparam int CFG_DATA_W        = 9;
  localparam int CFG_IDX_W         = 2;
  localparam int SHIFT_AMOUNT      = 2;

  typedef logic [HEAT_W-1:0]     heat_t;
  typedef logic [HEAT_W+1:0]     heat_sum_t;   // four 8-bit pixels
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

  localparam cfg_data_t WIDTH_RESET  = 9'd64;
  localparam cfg_data_t HEIGHT_RESET = 9'd32;
  localparam cfg_data_t MIN_WIDTH    = 9'd3;
  localparam cfg_data_t MIN_HEIGHT   = 9'd2;
  localparam cfg_data_t MAX_HEIGHT   = 9'd256;

  localparam heat_t DECAY = 8'd4;

endpackage

@@ hdl/fcdf_in_if.sv @@
interface fcdf_in_if;
  logic          valid;
  logic          ready;
  fcdf_pkg::heat_t heat_in;

  modport source (output valid, output heat_in, input ready);
  modport sink   (input valid, input heat_in, output ready);
endinterface

@@ hdl/fcdf_out_if.sv @@
interface fcdf_out_if;
  logic           valid;
  logic           ready;
  fcdf_pkg::pos_t  out_row;
  fcdf_pkg::pos_t  out_column;
  fcdf_pkg::heat_t heat_out;
  logic           frame_done;

  modport source (output valid, output out_row, output out_column, output heat_out,
                  output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_column, input heat_out,
                  input frame_done, output ready);
endinterface

@@ hdl/fcdf_cfg_if.sv @@
interface fcdf_cfg_if;
  logic                 valid;
  logic                 ready;
  fcdf_pkg::cfg_idx_t  reg_index;
  fcdf_pkg::cfg_data_t wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ hdl/fcdf_line_buf.sv @@
module fcdf_line_buf #(
  parameter int DEPTH = fcdf_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   addr,
  input  fcdf_pkg::heat_t wdata,
  output fcdf_pkg::heat_t rdata
);

  fcdf_pkg::heat_t mem [DEPTH];
  fcdf_pkg::heat_t rdata_r;

  // read-first: the old entry comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fire_cellular_decay_filter_core.sv @@
// channel   | dir | handshake        | payload
// ----------+-----+------------------+-------------------------------------------
// in_chan   | in  | valid / ready    | heat_in (8b)
// out_chan  | out | valid / ready    | out_row, out_column, heat_out (8b), frame_done
// cfg_chan  | in  | valid / ready=1  | reg_index (2b), wr_data (9b)
//
// One pixel item per clock sustained while out_chan does not stall; a result passes
// from the stage register into the output register, where it is offered on out_chan
// (line-buffer read into the stage register, then output register).
// The line buffer is a single read-first port: one read-modify-write per item past column 0.
// Reset (rst_n, sync, low) clears counters and handshake state and sets the frame size
// to its defaults; the line buffer is not cleared and needs no clearing pass.
// Output stalls back up through the stage register into in_chan.ready.
module fire_cellular_decay_filter_core #(
  parameter int MAX_WIDTH = fcdf_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  fcdf_in_if.sink           in_chan,
  fcdf_out_if.source        out_chan,
  fcdf_cfg_if.sink          cfg_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH - 1);

  // configuration
  fcdf_pkg::cfg_data_t frame_width_r, frame_height_r;
  logic                cfg_fire;
  logic                cfg_hit;

  // position and the two pixels to the left
  logic [CW-1:0]       col_r, col_nxt, last_col;
  fcdf_pkg::pos_t      row_r, row_nxt, last_row;
  fcdf_pkg::heat_t     left_r, left_left_r;

  // stage register, waits for line buffer data
  logic                s1_v_r;
  fcdf_pkg::heat_t     s1_heat_r, s1_left_r, s1_ll_r;
  fcdf_pkg::pos_t      s1_row_r, s1_col_r;
  logic                s1_done_r;

  // output register
  logic                out_v_r;
  fcdf_pkg::pos_t      out_row_r, out_col_r;
  fcdf_pkg::heat_t     out_heat_r;
  logic                out_done_r;

  logic                in_ready, in_fire, s1_move, produce, at_last;
  logic                lb_en;
  logic [CW-1:0]       lb_addr;
  fcdf_pkg::heat_t     above;
  fcdf_pkg::heat_sum_t sum;
  fcdf_pkg::heat_t     avg, decayed;

  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid;
  // only mapped registers restart the frame; other indexes are ignored
  assign cfg_hit        = cfg_fire &&
                          ((cfg_chan.reg_index == fcdf_pkg::REG_FRAME_WIDTH) ||
                           (cfg_chan.reg_index == fcdf_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= fcdf_pkg::WIDTH_RESET;
      frame_height_r <= fcdf_pkg::HEIGHT_RESET;
    end else if (cfg_fire) begin
      if (cfg_chan.reg_index == fcdf_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_chan.wr_data;
      end
      if (cfg_chan.reg_index == fcdf_pkg::REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_chan.wr_data;
      end
    end
  end

  // saturated frame size as last indexes
  always_comb begin
    if (frame_width_r < fcdf_pkg::MIN_WIDTH) begin
      last_col = CW'(2);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      last_col = COL_MAX;
    end else begin
      last_col = CW'(frame_width_r - 9'd1);
    end
    if (frame_height_r < fcdf_pkg::MIN_HEIGHT) begin
      last_row = 8'd1;
    end else if (frame_height_r > fcdf_pkg::MAX_HEIGHT) begin
      last_row = 8'd255;
    end else begin
      last_row = 8'(frame_height_r - 9'd1);
    end
  end

  // handshake
  assign s1_move          = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_ready         = !s1_v_r || s1_move;
  assign in_chan.ready    = in_ready;
  assign in_fire          = in_chan.valid && in_ready;

  // interior pixel: not first row of input, down-right at column >= 2
  assign produce = (row_r != '0) && (col_r >= CW'(2));
  assign at_last = (col_r == last_col);

  // the row above at column-1 is read while the previous pixel replaces it
  assign lb_en   = in_fire && (col_r != '0);
  assign lb_addr = col_r - CW'(1);

  fcdf_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk   (clk),
    .en    (lb_en),
    .addr  (lb_addr),
    .wdata (left_r),
    .rdata (above)
  );

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (at_last) begin
      col_nxt = '0;
      row_nxt = (row_r == last_row) ? '0 : row_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      left_left_r <= '0;
    end else if (cfg_hit) begin
      // a write to a mapped register restarts the frame
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      left_left_r <= '0;
    end else if (in_fire) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= in_chan.heat_in;
      left_left_r <= left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= produce;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_heat_r <= in_chan.heat_in;
      s1_left_r <= left_r;
      s1_ll_r   <= left_left_r;
      s1_row_r  <= row_r - 8'd1;
      s1_col_r  <= fcdf_pkg::POS_W'(col_r - CW'(1));
      s1_done_r <= (row_r == last_row) && at_last;
    end
  end

  // average of four, then cool by DECAY clamped at zero
  assign sum     = fcdf_pkg::heat_sum_t'(above) + fcdf_pkg::heat_sum_t'(s1_ll_r)
                 + fcdf_pkg::heat_sum_t'(s1_left_r) + fcdf_pkg::heat_sum_t'(s1_heat_r);
  assign avg     = sum[fcdf_pkg::SHIFT_AMOUNT +: fcdf_pkg::HEAT_W];
  assign decayed = (avg >= fcdf_pkg::DECAY) ? avg - fcdf_pkg::DECAY : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_chan.ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_heat_r <= decayed;
      out_done_r <= s1_done_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.out_row    = out_row_r;
  assign out_chan.out_column = out_col_r;
  assign out_chan.heat_out   = out_heat_r;
  assign out_chan.frame_done = out_done_r;

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col)
    else $error("column counter past end of row");

  a_border_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_fire && !produce |=> !s1_v_r)
    else $error("border pixel entered the pipeline");

  a_interior_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && produce |=> s1_v_r)
    else $error("interior pixel lost");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
